/* hw/rtl/esin_pkg.sv */
// ----------------------------------------------------------------------------
// esin_pkg: shared definitions for the exp-of-sine series block
// Fixed-point constants, derived widths, the multiply-divide unit command and
// status types, and the saturating helpers used by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package esin_pkg;

   // Largest accepted term count; larger requests are clamped to it.
   localparam int MAX_TERMS = 16;

   // Term index counter holds 0 .. MAX_TERMS + 1.
   localparam int CNT_W = $clog2(MAX_TERMS + 2);

   // Largest recurrence divisor: (2i-2)(2i-1) for the sine series, i for exp.
   localparam int K_SIN_MAX = (2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1);
   localparam int K_MAX     = (K_SIN_MAX > MAX_TERMS) ? K_SIN_MAX : MAX_TERMS;
   localparam int K_W       = $clog2(K_MAX + 1);

   // Multiply-divide unit timing.
   localparam int DIV_BITS   = 8;               // quotient bits per cycle
   localparam int DIV_CYCLES = 64 / DIV_BITS;
   localparam int MUL_LAST   = 4;               // four partial products, last add
   localparam int STEP_W     = $clog2(((MUL_LAST + 1) > DIV_CYCLES) ?
                                      (MUL_LAST + 1) : DIV_CYCLES);

   // Q32.32 constants.
   localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
   localparam logic [62:0] ONE_MAG  = 63'h0000_0001_0000_0000;
   localparam logic [62:0] MAG_MAX  = {63{1'b1}};
   localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MIN  = 64'h8000_0000_0000_0000;

   localparam logic [31:0] THRESHOLD_RESET = 32'd43;

   typedef struct packed {
      logic           start;
      logic [63:0]    a_mag;
      logic [63:0]    b_mag;
      logic [K_W-1:0] divisor;
   } esin_cmd_type;

   typedef struct packed {
      logic        done;
      logic [62:0] quot;
   } esin_sts_type;

   // Sine recurrence divisor (2i-2)(2i-1).
   function automatic logic [K_W-1:0] sine_divisor(input logic [CNT_W-1:0] idx);
      int v;
      v = (2 * int'(idx) - 2) * (2 * int'(idx) - 1);
      return K_W'(v);
   endfunction

   // Two's complement value of a sign and 63-bit magnitude.
   function automatic logic [63:0] signed_of(input logic neg, input logic [62:0] mag);
      logic [63:0] v;
      v = {1'b0, mag};
      return neg ? (~v + 64'd1) : v;
   endfunction

   // Magnitude of a signed 64-bit value; the most negative value gives 2^63.
   function automatic logic [63:0] mag_of(input logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   // Signed add that clamps at the 64-bit limits.
   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? NEG_MIN : POS_MAX;
      end
      return s[63:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/exp_of_sine_series.sv */
// ----------------------------------------------------------------------------
// exp_of_sine_series: e^(sin x) by two truncated Maclaurin series
// Top level with the threshold register, the sequencer, the shared
// multiply-divide unit and the result register.
// ----------------------------------------------------------------------------
// An item carries an angle in signed Q3.28 and a term count n (values above
// 16 act as 16). The block sums up to n sine terms to get u, then 1 plus up
// to n terms of u^i/i!, both in signed Q32.32 with saturation, and returns
// e^(sin x) together with u. Each series stops at the first term whose
// magnitude is below the stop threshold register, without adding that term.
// Every term but the first sine term, and the initial x*x, takes one pass
// through a single shared multiply-divide unit: four 32x32 partial products
// and then division at eight quotient bits per cycle. One item is worked
// on at a time and req_stall is high for that whole time; a finished item
// waits in the output register, so the next item can be taken while it is
// still stalled there. The threshold register resets to 43 (about 1e-8)
// and should be written only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module exp_of_sine_series
   import esin_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   // Input items.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_angle,
   input  wire logic [4:0]  req_term_count,

   // Result items.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result,
   output logic [63:0]      rsp_sine_value,

   // Stop threshold register write.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   logic [31:0]  threshold_ff, threshold_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_result_ff, rsp_result_in;
   logic [63:0]  rsp_sine_value_ff, rsp_sine_value_in;

   esin_cmd_type unit_cmd;
   esin_sts_type unit_sts;
   logic         busy;
   logic         finish;
   logic [63:0]  seq_result;
   logic [63:0]  seq_sine_value;
   logic         start;
   logic         out_free;

   // A write is always taken; the threshold is read throughout an item, so it should be written only between items.
   assign csr_ready = 1'b1;

   assign req_stall = busy;
   assign start     = req_valid && !busy;

   // The output register can take a new item when it is empty or draining.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   esin_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .angle      (req_angle),
      .term_count (req_term_count),
      .threshold  (threshold_ff),
      .out_free   (out_free),
      .unit_sts   (unit_sts),
      .unit_cmd   (unit_cmd),
      .busy       (busy),
      .finish     (finish),
      .result     (seq_result),
      .sine_value (seq_sine_value)
   );

   esin_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .sts   (unit_sts)
   );

   always_comb begin
      threshold_in      = threshold_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_result_in     = rsp_result_ff;
      rsp_sine_value_in = rsp_sine_value_ff;
      if (csr_valid && csr_ready) begin
         threshold_in = csr_data;
      end
      if (finish && out_free) begin
         rsp_valid_in      = 1'b1;
         rsp_result_in     = seq_result;
         rsp_sine_value_in = seq_sine_value;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff     <= rsp_result_in;
      rsp_sine_value_ff <= rsp_sine_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result     = rsp_result_ff;
   assign rsp_sine_value = rsp_sine_value_ff;

endmodule

`default_nettype wire

/* hw/rtl/esin_muldiv.sv */
// ----------------------------------------------------------------------------
// esin_muldiv: shared Q32.32 multiply and integer divide unit
// Multiplies two 64-bit magnitudes with one 32x32 multiplier over four
// passes, keeps bits 94:32 with saturation, then divides by a small integer
// eight quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esin_muldiv
   import esin_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire esin_cmd_type cmd,
   output esin_sts_type      sts
);

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_MUL  = 2'd1;
   localparam logic [1:0] U_SAT  = 2'd2;
   localparam logic [1:0] U_DIV  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [63:0]       a_ff, a_in;
   logic [63:0]       b_ff, b_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [63:0]       prod_ff, prod_in;
   logic [127:0]      acc_ff, acc_in;
   logic [63:0]       dvd_ff, dvd_in;
   logic [K_W-1:0]    rem_ff, rem_in;

   logic [31:0]       a_half;
   logic [31:0]       b_half;
   logic [63:0]       mul_out;
   logic [127:0]      addend;
   logic [62:0]       sat_mag;
   logic [63:0]       dvd_step;
   logic [K_W-1:0]    rem_step;

   // Pass order: low*low, low*high, high*low, high*high.
   assign a_half  = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half  = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign mul_out = a_half * b_half;

   // The product registered in the previous pass, placed at its weight.
   always_comb begin
      case (step_ff)
         STEP_W'(1): addend = {64'd0, prod_ff};
         STEP_W'(2),
         STEP_W'(3): addend = {32'd0, prod_ff, 32'd0};
         STEP_W'(4): addend = {prod_ff, 64'd0};
         default:    addend = 128'd0;
      endcase
   end

   assign sat_mag = (acc_ff[127:95] != 33'd0) ? MAG_MAX : acc_ff[94:32];

   // Restoring division, DIV_BITS quotient bits per cycle, quotient shifted
   // into the dividend register from the bottom.
   always_comb begin
      logic [K_W:0] trial;
      dvd_step = dvd_ff;
      rem_step = rem_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial    = {rem_step, dvd_step[63]};
         dvd_step = {dvd_step[62:0], 1'b0};
         if (trial >= {1'b0, k_ff}) begin
            trial       = trial - {1'b0, k_ff};
            dvd_step[0] = 1'b1;
         end
         rem_step = trial[K_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               a_in     = cmd.a_mag;
               b_in     = cmd.b_mag;
               k_in     = cmd.divisor;
               acc_in   = 128'd0;
               step_in  = '0;
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            if (step_ff != STEP_W'(MUL_LAST)) begin
               prod_in = mul_out;
            end
            acc_in = acc_ff + addend;
            if (step_ff == STEP_W'(MUL_LAST)) begin
               state_in = U_SAT;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         U_SAT: begin
            dvd_in   = {1'b0, sat_mag};
            rem_in   = '0;
            step_in  = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            if (step_ff == STEP_W'(DIV_CYCLES - 1)) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
   end

   assign sts.done = done_ff;
   assign sts.quot = dvd_ff[62:0];

   // A new operation may only be started while the unit is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == U_IDLE)
      else $error("muldiv started while busy");

   // Completion follows the last division cycle, and the quotient fits 63 bits.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(state_ff) == U_DIV) && !dvd_ff[63])
      else $error("muldiv completion out of sequence");

endmodule

`default_nettype wire

/* hw/rtl/esin_seq.sv */
// ----------------------------------------------------------------------------
// esin_seq: series sequencer
// Walks the sine series and then the exponential series one term at a time,
// issuing each recurrence step to the shared multiply-divide unit, and keeps
// the saturating partial sums.
// ----------------------------------------------------------------------------
`default_nettype none

module esin_seq
   import esin_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [31:0]  angle,
   input  wire logic [4:0]   term_count,
   input  wire logic [31:0]  threshold,
   input  wire logic         out_free,
   input  wire esin_sts_type unit_sts,
   output esin_cmd_type      unit_cmd,
   output logic              busy,
   output logic              finish,
   output logic [63:0]       result,
   output logic [63:0]       sine_value
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_X2        = 3'd1;
   localparam logic [2:0] S_SIN_CHK   = 3'd2;
   localparam logic [2:0] S_SIN_OP    = 3'd3;
   localparam logic [2:0] S_EXP_START = 3'd4;
   localparam logic [2:0] S_EXP_OP    = 3'd5;
   localparam logic [2:0] S_EXP_CHK   = 3'd6;
   localparam logic [2:0] S_FINISH    = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic             op_start_ff, op_start_in;
   logic [63:0]      op_a_ff, op_a_in;
   logic [63:0]      op_b_ff, op_b_in;
   logic [K_W-1:0]   op_k_ff, op_k_in;
   logic             op_neg_ff, op_neg_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [62:0]      x2_ff, x2_in;
   logic             term_neg_ff, term_neg_in;
   logic [62:0]      term_mag_ff, term_mag_in;
   logic [63:0]      u_ff, u_in;
   logic [63:0]      sum_ff, sum_in;

   logic [63:0]      x_full;
   logic [63:0]      x_mag;
   logic [CNT_W-1:0] n_clamped;
   logic [CNT_W-1:0] i_next;
   logic [63:0]      u_mag;
   logic             below;
   logic [63:0]      term_val;

   assign x_full    = {{28{angle[31]}}, angle, 4'b0000};
   assign x_mag     = mag_of(x_full);
   assign n_clamped = (int'(term_count) > MAX_TERMS) ? CNT_W'(MAX_TERMS)
                                                      : CNT_W'(term_count);
   assign i_next    = i_ff + CNT_W'(1);
   assign u_mag     = mag_of(u_ff);
   assign below     = term_mag_ff < {31'd0, threshold};
   assign term_val  = signed_of(term_neg_ff, term_mag_ff);

   always_comb begin
      state_in    = state_ff;
      op_start_in = 1'b0;
      op_a_in     = op_a_ff;
      op_b_in     = op_b_ff;
      op_k_in     = op_k_ff;
      op_neg_in   = op_neg_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      x2_in       = x2_ff;
      term_neg_in = term_neg_ff;
      term_mag_in = term_mag_ff;
      u_in        = u_ff;
      sum_in      = sum_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               // x*x first; the first sine term is x itself.
               op_start_in = 1'b1;
               op_a_in     = x_mag;
               op_b_in     = x_mag;
               op_k_in     = K_W'(1);
               op_neg_in   = 1'b0;
               n_in        = n_clamped;
               i_in        = CNT_W'(1);
               term_neg_in = angle[31];
               term_mag_in = x_mag[62:0];
               u_in        = 64'd0;
               sum_in      = ONE_Q32;
               state_in    = S_X2;
            end
         end
         S_X2: begin
            if (unit_sts.done) begin
               x2_in    = unit_sts.quot;
               state_in = S_SIN_CHK;
            end
         end
         S_SIN_CHK: begin
            if ((i_ff > n_ff) || below) begin
               state_in = S_EXP_START;
            end else begin
               u_in = sat_add(u_ff, term_val);
               i_in = i_next;
               if (i_next > n_ff) begin
                  state_in = S_EXP_START;
               end else begin
                  // Next term is -(t * x^2) / ((2i-2)(2i-1)); x^2 is never negative.
                  op_start_in = 1'b1;
                  op_a_in     = {1'b0, term_mag_ff};
                  op_b_in     = {1'b0, x2_ff};
                  op_k_in     = sine_divisor(i_next);
                  op_neg_in   = !term_neg_ff;
                  state_in    = S_SIN_OP;
               end
            end
         end
         S_SIN_OP: begin
            if (unit_sts.done) begin
               term_neg_in = op_neg_ff;
               term_mag_in = unit_sts.quot;
               state_in    = S_SIN_CHK;
            end
         end
         S_EXP_START: begin
            i_in = CNT_W'(1);
            if (n_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               op_start_in = 1'b1;
               op_a_in     = {1'b0, ONE_MAG};
               op_b_in     = u_mag;
               op_k_in     = K_W'(1);
               op_neg_in   = u_ff[63];
               state_in    = S_EXP_OP;
            end
         end
         S_EXP_OP: begin
            if (unit_sts.done) begin
               term_neg_in = op_neg_ff;
               term_mag_in = unit_sts.quot;
               state_in    = S_EXP_CHK;
            end
         end
         S_EXP_CHK: begin
            if (below) begin
               state_in = S_FINISH;
            end else begin
               sum_in = sat_add(sum_ff, term_val);
               i_in   = i_next;
               if (i_next > n_ff) begin
                  state_in = S_FINISH;
               end else begin
                  op_start_in = 1'b1;
                  op_a_in     = {1'b0, term_mag_ff};
                  op_b_in     = u_mag;
                  op_k_in     = K_W'(i_next);
                  op_neg_in   = term_neg_ff ^ u_ff[63];
                  state_in    = S_EXP_OP;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         op_start_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         op_start_ff <= op_start_in;
      end
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      op_k_ff     <= op_k_in;
      op_neg_ff   <= op_neg_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      x2_ff       <= x2_in;
      term_neg_ff <= term_neg_in;
      term_mag_ff <= term_mag_in;
      u_ff        <= u_in;
      sum_ff      <= sum_in;
   end

   assign unit_cmd.start   = op_start_ff;
   assign unit_cmd.a_mag   = op_a_ff;
   assign unit_cmd.b_mag   = op_b_ff;
   assign unit_cmd.divisor = op_k_ff;

   assign busy       = state_ff != S_IDLE;
   assign finish     = state_ff == S_FINISH;
   assign result     = sum_ff;
   assign sine_value = u_ff;

   // A unit operation is only started from a state that waits for it.
   assert property (@(posedge clock) disable iff (reset)
      op_start_ff |-> (state_ff == S_X2) || (state_ff == S_SIN_OP) ||
                      (state_ff == S_EXP_OP))
      else $error("unit started outside a wait state");

   // Unit results only arrive while the sequencer is waiting for them.
   assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> (state_ff == S_X2) || (state_ff == S_SIN_OP) ||
                        (state_ff == S_EXP_OP))
      else $error("unit result arrived unexpectedly");

endmodule

`default_nettype wire
